>>> hdl/cvsd_pkg.sv
// shared types and constants for the vehicle signal decoder
// used by the front classifier, the command queue and the back end
package cvsd_pkg;

  localparam int unsigned IdW    = 29;
  localparam int unsigned ValW   = 17;
  localparam int unsigned QDepth = 2;

  localparam logic [IdW-1:0] IdRpm      = 29'h0CF00400;
  localparam logic [IdW-1:0] IdGear     = 29'h18F00503;
  localparam logic [IdW-1:0] IdTurn     = 29'h0CFDCCE6;
  localparam logic [IdW-1:0] IdSteer    = 29'h18F0090B;
  localparam logic [IdW-1:0] IdSpeed    = 29'h18FEF100;
  localparam logic [IdW-1:0] IdDoorOpen = 29'h18FF2AEF;
  localparam logic [IdW-1:0] IdDoorLock = 29'h18FEF1EF;

  localparam logic [8:0]  GearOffset  = 9'd125;
  localparam logic [15:0] RawInvalid  = 16'hFFFF;
  // 31.374 rad scaled by 1024, rounded
  localparam logic [16:0] SteerOffset = 17'd32127;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RPM,
    KIND_GEAR,
    KIND_TURN,
    KIND_STEER,
    KIND_SPEED,
    KIND_DOOR_AJAR,
    KIND_DOOR_LATCH
  } kind_e;

  typedef struct packed {
    logic             updated;
    logic             wr;
    kind_e            kind;
    logic [ValW-1:0]  val;
  } cmd_t;

endpackage

>>> hdl/cvsd_front.sv
// front end: classifies a frame by id and pre-scales its signal value
// depends on cvsd_pkg
module cvsd_front (
  input  logic [31:0]    frame_id_i,
  input  logic [7:0]     byte0_i,
  input  logic [7:0]     byte1_i,
  input  logic [7:0]     byte2_i,
  input  logic [7:0]     byte3_i,
  input  logic [7:0]     byte4_i,
  output cvsd_pkg::cmd_t cmd_o
);

  logic [cvsd_pkg::IdW-1:0] id;
  logic [15:0]              raw_rpm;
  logic [15:0]              raw_steer;
  logic [15:0]              raw_speed;
  logic [8:0]               gear_val;
  logic [16:0]              steer_val;

  assign id        = frame_id_i[cvsd_pkg::IdW-1:0];
  assign raw_rpm   = {byte4_i, byte3_i};
  assign raw_steer = {byte1_i, byte0_i};
  assign raw_speed = {byte2_i, byte1_i};
  assign gear_val  = {1'b0, byte0_i} - cvsd_pkg::GearOffset;
  assign steer_val = {1'b0, raw_steer} - cvsd_pkg::SteerOffset;

  always_comb begin
    cmd_o.updated = 1'b1;
    cmd_o.wr      = 1'b1;
    cmd_o.kind    = cvsd_pkg::KIND_NONE;
    cmd_o.val     = '0;
    if (!frame_id_i[31]) begin
      cmd_o.updated = 1'b0;
      cmd_o.wr      = 1'b0;
    end else begin
      case (id)
        cvsd_pkg::IdRpm: begin
          cmd_o.kind = cvsd_pkg::KIND_RPM;
          cmd_o.wr   = (raw_rpm != cvsd_pkg::RawInvalid);
          cmd_o.val  = {1'b0, raw_rpm};
        end
        cvsd_pkg::IdGear: begin
          cmd_o.kind = cvsd_pkg::KIND_GEAR;
          cmd_o.val  = {8'd0, gear_val};
        end
        cvsd_pkg::IdTurn: begin
          cmd_o.kind = cvsd_pkg::KIND_TURN;
          cmd_o.val  = {13'd0, byte1_i[3:0]};
        end
        cvsd_pkg::IdSteer: begin
          cmd_o.kind = cvsd_pkg::KIND_STEER;
          cmd_o.wr   = (raw_steer != cvsd_pkg::RawInvalid);
          cmd_o.val  = steer_val;
        end
        cvsd_pkg::IdSpeed: begin
          // whole km/h is the high byte of the raw value
          cmd_o.kind = cvsd_pkg::KIND_SPEED;
          cmd_o.wr   = (raw_speed != cvsd_pkg::RawInvalid);
          cmd_o.val  = {9'd0, byte2_i};
        end
        cvsd_pkg::IdDoorOpen: begin
          cmd_o.kind = cvsd_pkg::KIND_DOOR_AJAR;
          cmd_o.val  = {16'd0, ~byte1_i[7]};
        end
        cvsd_pkg::IdDoorLock: begin
          cmd_o.kind = cvsd_pkg::KIND_DOOR_LATCH;
          cmd_o.val  = {15'd0, byte4_i[3:2]};
        end
        default: begin
          cmd_o.updated = 1'b0;
          cmd_o.wr      = 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hdl/cvsd_queue.sv
// two-entry command queue between front and back end
// depends on cvsd_pkg
module cvsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cvsd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           not_empty_o,
  input  logic           pop_i,
  output cvsd_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = $clog2(cvsd_pkg::QDepth);
  localparam int unsigned CntW = $clog2(cvsd_pkg::QDepth + 1);

  cvsd_pkg::cmd_t  mem_q [cvsd_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o      = (cnt_q == CntW'(cvsd_pkg::QDepth));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(cvsd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(cvsd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/cvsd_back.sv
// back end: applies queued commands to the held signals, drives the result register
// depends on cvsd_pkg
module cvsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cvsd_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               updated_o,
  output logic [15:0]        rpm_eighths_o,
  output logic signed [8:0]  gear_o,
  output logic [3:0]         blinker_o,
  output logic signed [16:0] steer_angle_o,
  output logic [7:0]         road_speed_o,
  output logic               door_ajar_o,
  output logic [1:0]         door_latch_o
);

  logic        valid_q;
  logic        updated_q, updated_d;
  logic [15:0] rpm_q, rpm_d;
  logic [8:0]  gear_q, gear_d;
  logic [3:0]  turn_q, turn_d;
  logic [16:0] steer_q, steer_d;
  logic [7:0]  speed_q, speed_d;
  logic        door_ajar_q, door_ajar_d;
  logic [1:0]  door_latch_q, door_latch_d;
  logic        take;

  // result register frees up when empty or being taken
  assign take      = cmd_valid_i && (!valid_q || !out_stall_i);
  assign cmd_pop_o = take;

  always_comb begin
    updated_d    = cmd_i.updated;
    rpm_d        = rpm_q;
    gear_d       = gear_q;
    turn_d       = turn_q;
    steer_d      = steer_q;
    speed_d      = speed_q;
    door_ajar_d  = door_ajar_q;
    door_latch_d = door_latch_q;
    if (cmd_i.wr) begin
      case (cmd_i.kind)
        cvsd_pkg::KIND_RPM:        rpm_d        = cmd_i.val[15:0];
        cvsd_pkg::KIND_GEAR:       gear_d       = cmd_i.val[8:0];
        cvsd_pkg::KIND_TURN:       turn_d       = cmd_i.val[3:0];
        cvsd_pkg::KIND_STEER:      steer_d      = cmd_i.val;
        cvsd_pkg::KIND_SPEED:      speed_d      = cmd_i.val[7:0];
        cvsd_pkg::KIND_DOOR_AJAR:  door_ajar_d  = cmd_i.val[0];
        cvsd_pkg::KIND_DOOR_LATCH: door_latch_d = cmd_i.val[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      updated_q    <= 1'b0;
      rpm_q        <= '0;
      gear_q       <= '0;
      turn_q       <= '0;
      steer_q      <= '0;
      speed_q      <= '0;
      door_ajar_q  <= 1'b0;
      door_latch_q <= '0;
    end else begin
      if (take) begin
        valid_q      <= 1'b1;
        updated_q    <= updated_d;
        rpm_q        <= rpm_d;
        gear_q       <= gear_d;
        turn_q       <= turn_d;
        steer_q      <= steer_d;
        speed_q      <= speed_d;
        door_ajar_q  <= door_ajar_d;
        door_latch_q <= door_latch_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign updated_o     = updated_q;
  assign rpm_eighths_o = rpm_q;
  assign gear_o        = gear_q;
  assign blinker_o     = turn_q;
  assign steer_angle_o = steer_q;
  assign road_speed_o  = speed_q;
  assign door_ajar_o   = door_ajar_q;
  assign door_latch_o  = door_latch_q;

endmodule

>>> hdl/can_vehicle_signal_decoder_core.sv
// vehicle signal decoder top level: front classifier, command queue, back end
// depends on cvsd_pkg, cvsd_front, cvsd_queue, cvsd_back
// datapath: queue write, then result register; a stalled result register leaves requests in the queue
// throughput: one request per cycle; the two-entry queue stalls input only when full
// reset: asynchronous active low, clears queue, result valid and all held signals to zero
module can_vehicle_signal_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        frame_id_i,
  input  logic [7:0]         byte0_i,
  input  logic [7:0]         byte1_i,
  input  logic [7:0]         byte2_i,
  input  logic [7:0]         byte3_i,
  input  logic [7:0]         byte4_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               updated_o,
  output logic [15:0]        rpm_eighths_o,
  output logic signed [8:0]  gear_o,
  output logic [3:0]         blinker_o,
  output logic signed [16:0] steer_angle_o,
  output logic [7:0]         road_speed_o,
  output logic               door_ajar_o,
  output logic [1:0]         door_latch_o
);

  cvsd_pkg::cmd_t front_cmd;
  cvsd_pkg::cmd_t queue_cmd;
  logic           queue_full;
  logic           queue_not_empty;
  logic           queue_pop;

  cvsd_front u_front (
    .frame_id_i (frame_id_i),
    .byte0_i    (byte0_i),
    .byte1_i    (byte1_i),
    .byte2_i    (byte2_i),
    .byte3_i    (byte3_i),
    .byte4_i    (byte4_i),
    .cmd_o      (front_cmd)
  );

  cvsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_cmd_i  (front_cmd),
    .full_o      (queue_full),
    .not_empty_o (queue_not_empty),
    .pop_i       (queue_pop),
    .pop_cmd_o   (queue_cmd)
  );

  assign in_stall_o = queue_full;

  cvsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_not_empty),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .updated_o     (updated_o),
    .rpm_eighths_o (rpm_eighths_o),
    .gear_o        (gear_o),
    .blinker_o     (blinker_o),
    .steer_angle_o (steer_angle_o),
    .road_speed_o  (road_speed_o),
    .door_ajar_o   (door_ajar_o),
    .door_latch_o  (door_latch_o)
  );

endmodule

>>> test/can_vehicle_signal_decoder_core_test.sv
// testbench for can_vehicle_signal_decoder_core: directed frame table, then random frames
// every request is run through a local decoder and each result is checked field by field
// needs only the rtl of the block and its package
`timescale 1ns / 100ps

module can_vehicle_signal_decoder_core_test;

  typedef enum logic [28:0] {
    ID_ENGINE     = 29'h0CF00400,
    ID_GEAR       = 29'h18F00503,
    ID_TURN       = 29'h0CFDCCE6,
    ID_STEER      = 29'h18F0090B,
    ID_SPEED      = 29'h18FEF100,
    ID_DOOR_AJAR  = 29'h18FF2AEF,
    ID_DOOR_LATCH = 29'h18FEF1EF
  } msg_id_e;

  localparam logic [15:0] RAW_INVALID  = 16'hFFFF;
  localparam logic [8:0]  GEAR_BIAS    = 9'd125;
  localparam logic [16:0] STEER_BIAS   = 17'd32127;
  localparam int          RANDOM_COUNT = 2000;
  localparam int          QUIET_TAIL   = 150;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          PRINT_CAP    = 40;

  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  d3;
    logic [7:0]  d4;
  } frame_t;

  typedef struct packed {
    logic               updated;
    logic [15:0]        rpm;
    logic signed [8:0]  gear;
    logic [3:0]         turn;
    logic signed [16:0] steer;
    logic [7:0]         speed;
    logic               door_ajar;
    logic [1:0]         door_latch;
  } signals_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    signals_t r;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        frame_id = '0;
  logic [7:0]         byte0 = '0;
  logic [7:0]         byte1 = '0;
  logic [7:0]         byte2 = '0;
  logic [7:0]         byte3 = '0;
  logic [7:0]         byte4 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               updated;
  logic [15:0]        rpm_eighths;
  logic signed [8:0]  gear;
  logic [3:0]         blinker;
  logic signed [16:0] steer_angle;
  logic [7:0]         road_speed;
  logic               door_ajar;
  logic [1:0]         door_latch;

  can_vehicle_signal_decoder_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .frame_id_i    (frame_id),
    .byte0_i       (byte0),
    .byte1_i       (byte1),
    .byte2_i       (byte2),
    .byte3_i       (byte3),
    .byte4_i       (byte4),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .updated_o     (updated),
    .rpm_eighths_o (rpm_eighths),
    .gear_o        (gear),
    .blinker_o     (blinker),
    .steer_angle_o (steer_angle),
    .road_speed_o  (road_speed),
    .door_ajar_o   (door_ajar),
    .door_latch_o  (door_latch)
  );

  always #5 clk = ~clk;

  // held signals of the local decoder
  logic [15:0]        held_rpm = '0;
  logic signed [8:0]  held_gear = '0;
  logic [3:0]         held_turn = '0;
  logic signed [16:0] held_steer = '0;
  logic [7:0]         held_speed = '0;
  logic               held_door_ajar = 1'b0;
  logic [1:0]         held_door_latch = '0;

  msg_id_e  known_ids [7] = '{ID_ENGINE, ID_GEAR, ID_TURN, ID_STEER, ID_SPEED,
                             ID_DOOR_AJAR, ID_DOOR_LATCH};
  row_t     frame_rows [$];
  signals_t expected_signals [$];
  int       frame_total;
  int       next_frame = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       error_count = 0;
  int       cycle_count = 0;
  bit       calm;
  row_t     sent_row;
  signals_t decoded;
  signals_t want;

  function automatic signals_t decode_frame(frame_t f);
    signals_t    r;
    logic [15:0] raw;
    r.updated = 1'b0;
    if (f.word[31]) begin
      r.updated = 1'b1;
      case (f.word[28:0])
        ID_ENGINE: begin
          raw = {f.d4, f.d3};
          if (raw != RAW_INVALID) held_rpm = raw;
        end
        ID_GEAR: held_gear = {1'b0, f.d0} - GEAR_BIAS;
        ID_TURN: held_turn = f.d1[3:0];
        ID_STEER: begin
          raw = {f.d1, f.d0};
          if (raw != RAW_INVALID) held_steer = {1'b0, raw} - STEER_BIAS;
        end
        ID_SPEED: begin
          raw = {f.d2, f.d1};
          if (raw != RAW_INVALID) held_speed = raw[15:8];
        end
        ID_DOOR_AJAR: held_door_ajar = ~f.d1[7];
        ID_DOOR_LATCH: held_door_latch = f.d4[3:2];
        default: r.updated = 1'b0;
      endcase
    end
    r.rpm        = held_rpm;
    r.gear       = held_gear;
    r.turn       = held_turn;
    r.steer      = held_steer;
    r.speed      = held_speed;
    r.door_ajar  = held_door_ajar;
    r.door_latch = held_door_latch;
    return r;
  endfunction

  function automatic frame_t random_frame();
    frame_t      f;
    logic [28:0] id;
    int          pick;
    f    = {$urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    id   = known_ids[$urandom_range(0, 6)];
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      f.word = {1'b1, 2'($urandom), id};
      // now and then the raw value is the invalid marker
      if ($urandom_range(0, 4) == 0) begin
        case (id)
          ID_ENGINE: {f.d4, f.d3} = RAW_INVALID;
          ID_STEER:  {f.d1, f.d0} = RAW_INVALID;
          ID_SPEED:  {f.d2, f.d1} = RAW_INVALID;
          default: ;
        endcase
      end
    end else if (pick < 85) begin
      f.word = {1'b0, 2'($urandom), id};
    end else if (pick < 93) begin
      f.word = {1'b1, 2'($urandom), id ^ (29'd1 << $urandom_range(0, 28))};
    end
    return f;
  endfunction

  task automatic add_frame(logic [31:0] w, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                           logic [7:0] d, logic [7:0] e);
    row_t row;
    row.f     = {w, a, b, c, d, e};
    row.typed = 1'b0;
    row.r     = '0;
    frame_rows.insert(frame_rows.size(), row);
  endtask

  task automatic add_typed(logic [31:0] w, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                           logic [7:0] d, logic [7:0] e, signals_t r);
    row_t row;
    row.f     = {w, a, b, c, d, e};
    row.typed = 1'b1;
    row.r     = r;
    frame_rows.insert(frame_rows.size(), row);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      calm = (next_frame % 300) < 60;

      // result side
      if (out_valid && !out_stall) begin
        if (expected_signals.size() == 0) begin
          report_mismatch("result with no request pending", 32'(updated), 0);
        end else begin
          want = expected_signals.pop_front();
          if (updated !== want.updated)
            report_mismatch("updated", 32'(updated), 32'(want.updated));
          if (rpm_eighths !== want.rpm)
            report_mismatch("rpm_eighths", 32'(rpm_eighths), 32'(want.rpm));
          if (gear !== want.gear)
            report_mismatch("gear", 32'(gear), 32'(want.gear));
          if (blinker !== want.turn)
            report_mismatch("blinker", 32'(blinker), 32'(want.turn));
          if (steer_angle !== want.steer)
            report_mismatch("steer_angle", 32'(steer_angle), 32'(want.steer));
          if (road_speed !== want.speed)
            report_mismatch("road_speed", 32'(road_speed), 32'(want.speed));
          if (door_ajar !== want.door_ajar)
            report_mismatch("door_ajar", 32'(door_ajar), 32'(want.door_ajar));
          if (door_latch !== want.door_latch)
            report_mismatch("door_latch", 32'(door_latch), 32'(want.door_latch));
        end
      end
      if (next_frame >= frame_total - QUIET_TAIL) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end

      // request side
      if (in_valid && !in_stall) begin
        sent_row = frame_rows[next_frame];
        decoded  = decode_frame(sent_row.f);
        expected_signals.insert(expected_signals.size(), sent_row.typed ? sent_row.r : decoded);
        next_frame++;
        if (next_frame < frame_total - QUIET_TAIL && !calm && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 7);
      end
      // a stalled request is held as it is
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (next_frame < frame_total) begin
          in_valid <= 1'b1;
          frame_id <= frame_rows[next_frame].f.word;
          byte0    <= frame_rows[next_frame].f.d0;
          byte1    <= frame_rows[next_frame].f.d1;
          byte2    <= frame_rows[next_frame].f.d2;
          byte3    <= frame_rows[next_frame].f.d3;
          byte4    <= frame_rows[next_frame].f.d4;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    // standard frame carrying a known id is ignored
    add_typed(32'h0CF00400, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '0);
    add_typed(32'h8CF00400, 8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF,
              '{1'b1, 16'hFFFE, 9'sd0, 4'd0, 17'sd0, 8'd0, 1'b0, 2'd0});
    // invalid engine speed keeps the held value
    add_typed(32'h8CF00400, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
              '{1'b1, 16'hFFFE, 9'sd0, 4'd0, 17'sd0, 8'd0, 1'b0, 2'd0});
    // bits 30:29 do not take part in the match
    add_typed(32'hECF00400, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
              '{1'b1, 16'h0000, 9'sd0, 4'd0, 17'sd0, 8'd0, 1'b0, 2'd0});
    add_typed(32'h98F00503, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              '{1'b1, 16'h0000, -9'sd125, 4'd0, 17'sd0, 8'd0, 1'b0, 2'd0});
    // gear 0xff has no invalid check
    add_typed(32'h98F00503, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              '{1'b1, 16'h0000, 9'sd130, 4'd0, 17'sd0, 8'd0, 1'b0, 2'd0});
    add_typed(32'h98F0090B, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
              '{1'b1, 16'h0000, 9'sd130, 4'd0, -17'sd32127, 8'd0, 1'b0, 2'd0});
    add_frame(32'h98F0090B, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    add_frame(32'h98F0090B, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'h00);
    add_frame(32'h98FEF100, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
    add_frame(32'h98FEF100, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h00);
    add_frame(32'h98FEF100, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    add_frame(32'h8CFDCCE6, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
    add_frame(32'h8CFDCCE6, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hFF);
    add_frame(32'h98FF2AEF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00);
    add_frame(32'h98FF2AEF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    add_frame(32'h98FF2AEF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
    add_frame(32'h98FEF1EF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C);
    add_frame(32'h98FEF1EF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF3);
    add_frame(32'h98FEF1EF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04);
    add_frame(32'h98FEF1EF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08);
    // unknown ids, the all-zero id, a near miss of a known id and a standard frame with a known id
    add_frame(32'h9FFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_frame(32'h80000000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_frame(32'h8CF00401, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A);
    add_frame(32'h18F00503, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    repeat (RANDOM_COUNT) begin
      sent_row.f     = random_frame();
      sent_row.typed = 1'b0;
      sent_row.r     = '0;
      frame_rows.insert(frame_rows.size(), sent_row);
    end
    frame_total = frame_rows.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(next_frame == frame_total && !in_valid && expected_signals.size() == 0))
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_signals.size() != 0)
      report_mismatch("results never delivered", expected_signals.size(), 0);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
